FILE: design/blum_blum_shub_byte_generator_defines.svh
// Assertion macros shared by the generator RTL; empty when synthesized.
`ifndef BLUM_BLUM_SHUB_BYTE_GENERATOR_DEFINES_SVH
`define BLUM_BLUM_SHUB_BYTE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define BBS_ASSERT_CR(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("bbs assertion failed");
// Assertion on the module clock clk and reset rst_n.
`define BBS_ASSERT(lbl, prop) \
  `BBS_ASSERT_CR(lbl, clk, rst_n, prop)
`else
`define BBS_ASSERT_CR(lbl, ck, rstn, prop)
`define BBS_ASSERT(lbl, prop)
`endif
`endif

FILE: design/bbs_pkg.sv
// Types and constants of the Blum Blum Shub byte generator.
`default_nettype none
package bbs_pkg;

  // Field widths.
  localparam int MOD_W  = 40;
  localparam int SKIP_W = 16;
  localparam int BYTE_W = 8;
  // Squarings per skipped byte group are BYTE_W, so the count gains 3 bits.
  localparam int SQ_W   = SKIP_W + 3;
  localparam int CFG_IDX_W = 1;

  // Reset values of the configuration registers.
  localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_W'(21);
  localparam logic [SKIP_W-1:0] SKIP_RESET = '0;

  // Operation codes of an input item.
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP    = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_REDUCE,
    S_MULT,
    S_DONE
  } bbs_state_t;

endpackage
`default_nettype wire

FILE: design/blum_blum_shub_byte_generator.sv
// Blum Blum Shub byte generator top level: sequencer, state and output register.
//
// Usage: configuration writes (cfg_index 0 = modulus, 1 = skip_bytes) are taken
// every cycle on the cfg_valid / cfg_ready channel; write them only while idle.
// An input item with in_op = 0 loads in_seed as the state and then performs
// 8 * skip_bytes modular squarings; it produces no output item. An item with
// in_op = 1 produces one out_random_byte: eight inverted parity bits of the
// state, the first in bit 7, with a modular squaring after each bit.
// Each squaring runs on one shared double-and-add unit, one bit per cycle: a
// setup step in S_NEXT, a reduction over the state bits in S_REDUCE when the
// state is not already below the modulus (only possible right after a seed or
// a modulus change), then a multiplication over the modulus bits in S_MULT.
// With modulus 0 a squaring is skipped in S_NEXT and leaves the state unchanged.
// in_stall is high from acceptance until the item has finished; one item is
// processed at a time. The result sits in an output register, so the next item
// is taken while the byte waits; a byte that finishes while the previous one is
// still stalled waits in the sequencer until the output register frees up.
// Synchronous reset clears the state to 0, modulus to 21 and skip_bytes to 0.
`default_nettype none
`include "blum_blum_shub_byte_generator_defines.svh"
module blum_blum_shub_byte_generator import bbs_pkg::*; #(
  parameter int STATE_BITS = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input item channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_op,
  input  wire logic [MOD_W-1:0]     in_seed,
  // Result item channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [BYTE_W-1:0]    out_random_byte,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MOD_W-1:0]     cfg_data
);

  localparam int SW    = STATE_BITS;
  localparam int CW    = (SW > MOD_W) ? SW : MOD_W;
  localparam int CNT_W = $clog2(CW);
  localparam int MIW   = $clog2(MOD_W);

  bbs_state_t state_r, state_nxt;

  logic [MOD_W-1:0]  mod_r, mod_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [SW-1:0]     x_r, x_nxt;
  logic [MOD_W-1:0]  acc_r, acc_nxt;
  logic [MOD_W-1:0]  a_r, a_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SQ_W-1:0]   sq_left_r, sq_left_nxt;
  logic              op_r, op_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;

  logic [MOD_W-1:0]  unit_addend;
  logic [MOD_W-1:0]  unit_sum;
  logic              in_accept;
  logic              x_below_mod;

  assign in_stall        = (state_r != S_IDLE);
  assign in_accept       = in_valid && !in_stall;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_random_byte = out_byte_r;
  assign x_below_mod     = (CW'(x_r) < CW'(mod_r));

  // Shared modular double-and-add unit.
  bbs_modadd u_modadd (
    .acc     (acc_r),
    .addend  (unit_addend),
    .modulus (mod_r),
    .sum_mod (unit_sum)
  );

  // Reduction feeds the state one bit at a time; multiplication adds a when
  // the current multiplier bit is set.
  always_comb begin
    if (state_r == S_REDUCE) begin
      unit_addend = MOD_W'(x_r[SW-1]);
    end else if (a_r[cnt_r[MIW-1:0]]) begin
      unit_addend = a_r;
    end else begin
      unit_addend = '0;
    end
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    skip_nxt      = skip_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    cnt_nxt       = cnt_r;
    sq_left_nxt   = sq_left_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;

    // Configuration writes; indexes past the list are ignored.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODULUS: mod_nxt  = cfg_data;
        CFG_SKIP:    skip_nxt = cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end

    // The receiver takes the waiting byte.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt   = in_op;
          byte_nxt = '0;
          if (in_op == OP_SEED) begin
            x_nxt       = SW'(in_seed);
            sq_left_nxt = {skip_r, 3'b000};
          end else begin
            sq_left_nxt = SQ_W'(BYTE_W);
          end
          state_nxt = S_NEXT;
        end
      end

      S_NEXT: begin
        if (sq_left_r == '0) begin
          state_nxt = (op_r == OP_BYTE) ? S_DONE : S_IDLE;
        end else begin
          // Take the parity bit before each squaring of a byte item.
          if (op_r == OP_BYTE) begin
            byte_nxt = {byte_r[BYTE_W-2:0], ~^x_r};
          end
          acc_nxt = '0;
          if (mod_r == '0) begin
            sq_left_nxt = sq_left_r - SQ_W'(1);
          end else if (x_below_mod) begin
            a_nxt     = MOD_W'(x_r);
            cnt_nxt   = CNT_W'(MOD_W - 1);
            state_nxt = S_MULT;
          end else begin
            cnt_nxt   = CNT_W'(SW - 1);
            state_nxt = S_REDUCE;
          end
        end
      end

      // Long division remainder of the state, most significant bit first.
      S_REDUCE: begin
        acc_nxt = unit_sum;
        x_nxt   = x_r << 1;
        if (cnt_r == '0) begin
          a_nxt     = unit_sum;
          acc_nxt   = '0;
          cnt_nxt   = CNT_W'(MOD_W - 1);
          state_nxt = S_MULT;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end

      // Modular square by double-and-add over the bits of a.
      S_MULT: begin
        acc_nxt = unit_sum;
        if (cnt_r == '0) begin
          x_nxt       = SW'(unit_sum);
          sq_left_nxt = sq_left_r - SQ_W'(1);
          state_nxt   = S_NEXT;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end

      // Hand the byte to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= MOD_RESET;
      skip_r      <= SKIP_RESET;
      x_r         <= '0;
      sq_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      skip_r      <= skip_nxt;
      x_r         <= x_nxt;
      sq_left_r   <= sq_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    a_r        <= a_nxt;
    cnt_r      <= cnt_nxt;
    op_r       <= op_nxt;
    byte_r     <= byte_nxt;
    out_byte_r <= out_byte_nxt;
  end

  // A new byte appears only when the sequencer hands one over.
  `BBS_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE))
  // The multiplicand and the running product stay reduced.
  `BBS_ASSERT(a_mult_reduced, (state_r == S_MULT) |-> (a_r < mod_r && acc_r < mod_r))
  // The multiplier bit index stays inside the modulus width.
  `BBS_ASSERT(a_cnt_range, (state_r == S_MULT) |-> (cnt_r < CNT_W'(MOD_W)))
  // An idle sequencer has no squarings outstanding.
  `BBS_ASSERT(a_idle_clear, (state_r == S_IDLE) |-> (sq_left_r == '0))

endmodule
`default_nettype wire

FILE: design/bbs_modadd.sv
// Shared modular double-and-add unit: (2*acc + addend) mod modulus.
`default_nettype none
module bbs_modadd import bbs_pkg::*; (
  input  wire logic [MOD_W-1:0] acc,
  input  wire logic [MOD_W-1:0] addend,
  input  wire logic [MOD_W-1:0] modulus,
  output logic      [MOD_W-1:0] sum_mod
);

  logic [MOD_W+1:0] total;
  logic [MOD_W+1:0] mod_x1;
  logic [MOD_W+1:0] mod_x2;

  // With acc and addend below the modulus the sum stays below three moduli,
  // so at most one of the two multiples is subtracted.
  always_comb begin
    total  = {1'b0, acc, 1'b0} + {2'b00, addend};
    mod_x1 = {2'b00, modulus};
    mod_x2 = {1'b0, modulus, 1'b0};
    if (total >= mod_x2) begin
      sum_mod = MOD_W'(total - mod_x2);
    end else if (total >= mod_x1) begin
      sum_mod = MOD_W'(total - mod_x1);
    end else begin
      sum_mod = MOD_W'(total);
    end
  end

endmodule
`default_nettype wire
